### design/grid_astar_path_search_macros.svh
// Assertion shorthands used by the checker file.
`ifndef GRID_ASTAR_PATH_SEARCH_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_MACROS_SVH

// Checked outside reset only
`define GAP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included
`define GAP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### design/gap_pkg.sv
package gap_pkg;

  // Grid and result limits
  localparam int GRID_W      = 8;
  localparam int GRID_H      = 8;
  localparam int CELLS       = GRID_W * GRID_H;
  localparam int MAX_RESULTS = 64;

  // Input opcodes
  localparam logic OPC_LOAD   = 1'b0;
  localparam logic OPC_SEARCH = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_CELL   = 2'd0;
  localparam logic [1:0] ST_NOPATH = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [2:0] cell_x;
    logic [2:0] cell_y;
    logic       is_wall;
    logic [2:0] goal_x;
    logic [2:0] goal_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0] path_x;
    logic [2:0] path_y;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_RDGOAL,
    OP_INIT,
    OP_OUT_NOPATH,
    OP_OUT_FULL,
    OP_OUT_LAST,
    OP_OUT_NEXT,
    OP_D_INIT,
    OP_NEXT_D,
    OP_NB_RD,
    OP_OS_INIT,
    OP_OS_RD,
    OP_OS_CK,
    OP_SH_INIT,
    OP_SH_RD,
    OP_SH_WR,
    OP_INSERT,
    OP_CLOSE,
    OP_POP_RD,
    OP_POP,
    OP_SCAN_INIT,
    OP_CS_RD,
    OP_STEP_I
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic at_goal;
    logic d_end;
    logic d_center;
    logic nb_in;
    logic wall;
    logic os_end;
    logic os_hit;
    logic open_full;
    logic open_empty;
    logic sh_end;
    logic closed_full;
    logic cs_end;
    logic cs_hit;
    logic rt_hit;
    logic rt_stop;
    logic out_taken;
  } sts_t;

endpackage

### design/gap_ctrl.sv
module gap_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          opcode_i,
  input  gap_pkg::sts_t sts_i,
  output gap_pkg::cmd_t cmd_o,
  output logic          in_stall_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_RDGOAL = 5'd1;
  localparam logic [4:0] S_INIT   = 5'd2;
  localparam logic [4:0] S_EXP    = 5'd3;
  localparam logic [4:0] S_NB     = 5'd4;
  localparam logic [4:0] S_NBW    = 5'd5;
  localparam logic [4:0] S_ADV    = 5'd6;
  localparam logic [4:0] S_OSRD   = 5'd7;
  localparam logic [4:0] S_OSCK   = 5'd8;
  localparam logic [4:0] S_SHRD   = 5'd9;
  localparam logic [4:0] S_SHWR   = 5'd10;
  localparam logic [4:0] S_CLOSE  = 5'd11;
  localparam logic [4:0] S_POP    = 5'd12;
  localparam logic [4:0] S_POPD   = 5'd13;
  localparam logic [4:0] S_CSRD   = 5'd14;
  localparam logic [4:0] S_CSCK   = 5'd15;
  localparam logic [4:0] S_RT     = 5'd16;
  localparam logic [4:0] S_RTRD   = 5'd17;
  localparam logic [4:0] S_RTCK   = 5'd18;
  localparam logic [4:0] S_OUTRT  = 5'd19;
  localparam logic [4:0] S_OUTEND = 5'd20;

  logic [4:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // Next state and datapath operation
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = gap_pkg::OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == gap_pkg::OPC_SEARCH) begin
            cmd_o.op = gap_pkg::OP_START;
            state_d  = S_RDGOAL;
          end else begin
            cmd_o.op = gap_pkg::OP_LOAD;
          end
        end
      end
      S_RDGOAL: begin
        cmd_o.op = gap_pkg::OP_RDGOAL;
        state_d  = S_INIT;
      end
      S_INIT: begin
        if (sts_i.bad) begin
          cmd_o.op = gap_pkg::OP_OUT_NOPATH;
          state_d  = S_OUTEND;
        end else begin
          cmd_o.op = gap_pkg::OP_INIT;
          state_d  = S_EXP;
        end
      end
      S_EXP: begin
        if (sts_i.at_goal) begin
          state_d = S_RT;
        end else begin
          cmd_o.op = gap_pkg::OP_D_INIT;
          state_d  = S_NB;
        end
      end
      S_NB: begin
        priority if (sts_i.d_end) begin
          state_d = S_CLOSE;
        end else if (sts_i.d_center || !sts_i.nb_in) begin
          cmd_o.op = gap_pkg::OP_NEXT_D;
        end else begin
          cmd_o.op = gap_pkg::OP_NB_RD;
          state_d  = S_NBW;
        end
      end
      S_NBW: begin
        if (sts_i.wall) begin
          state_d = S_ADV;
        end else begin
          cmd_o.op = gap_pkg::OP_OS_INIT;
          state_d  = S_OSRD;
        end
      end
      S_ADV: begin
        cmd_o.op = gap_pkg::OP_NEXT_D;
        state_d  = S_NB;
      end
      S_OSRD: begin
        priority if (!sts_i.os_end) begin
          cmd_o.op = gap_pkg::OP_OS_RD;
          state_d  = S_OSCK;
        end else if (sts_i.open_full) begin
          cmd_o.op = gap_pkg::OP_OUT_FULL;
          state_d  = S_OUTEND;
        end else begin
          cmd_o.op = gap_pkg::OP_SH_INIT;
          state_d  = S_SHRD;
        end
      end
      S_OSCK: begin
        if (sts_i.os_hit) begin
          state_d = S_ADV;
        end else begin
          cmd_o.op = gap_pkg::OP_OS_CK;
          state_d  = S_OSRD;
        end
      end
      S_SHRD: begin
        if (sts_i.sh_end) begin
          cmd_o.op = gap_pkg::OP_INSERT;
          state_d  = S_ADV;
        end else begin
          cmd_o.op = gap_pkg::OP_SH_RD;
          state_d  = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.op = gap_pkg::OP_SH_WR;
        state_d  = S_SHRD;
      end
      S_CLOSE: begin
        if (sts_i.closed_full) begin
          cmd_o.op = gap_pkg::OP_OUT_FULL;
          state_d  = S_OUTEND;
        end else begin
          cmd_o.op = gap_pkg::OP_CLOSE;
          state_d  = S_POP;
        end
      end
      S_POP: begin
        if (sts_i.open_empty) begin
          cmd_o.op = gap_pkg::OP_OUT_NOPATH;
          state_d  = S_OUTEND;
        end else begin
          cmd_o.op = gap_pkg::OP_POP_RD;
          state_d  = S_POPD;
        end
      end
      S_POPD: begin
        cmd_o.op = gap_pkg::OP_POP;
        state_d  = S_CSRD;
      end
      S_CSRD: begin
        if (sts_i.cs_end) begin
          state_d = S_EXP;
        end else begin
          cmd_o.op = gap_pkg::OP_CS_RD;
          state_d  = S_CSCK;
        end
      end
      S_CSCK: begin
        if (sts_i.cs_hit) begin
          state_d = S_POP;
        end else begin
          cmd_o.op = gap_pkg::OP_STEP_I;
          state_d  = S_CSRD;
        end
      end
      S_RT: begin
        if (sts_i.rt_stop) begin
          cmd_o.op = gap_pkg::OP_OUT_LAST;
          state_d  = S_OUTEND;
        end else begin
          cmd_o.op = gap_pkg::OP_SCAN_INIT;
          state_d  = S_RTRD;
        end
      end
      S_RTRD: begin
        if (sts_i.cs_end) begin
          cmd_o.op = gap_pkg::OP_OUT_LAST;
          state_d  = S_OUTEND;
        end else begin
          cmd_o.op = gap_pkg::OP_CS_RD;
          state_d  = S_RTCK;
        end
      end
      S_RTCK: begin
        if (sts_i.rt_hit) begin
          cmd_o.op = gap_pkg::OP_OUT_NEXT;
          state_d  = S_OUTRT;
        end else begin
          cmd_o.op = gap_pkg::OP_STEP_I;
          state_d  = S_RTRD;
        end
      end
      S_OUTRT: begin
        if (sts_i.out_taken) state_d = S_RT;
      end
      S_OUTEND: begin
        if (sts_i.out_taken) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/gap_dp.sv
module gap_dp #(
  parameter int LIST_DEPTH = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gap_pkg::cmd_t        cmd_i,
  input  gap_pkg::in_word_t    in_word_i,
  input  logic                 out_stall_i,
  output gap_pkg::sts_t        sts_o,
  output logic                 out_valid_o,
  output gap_pkg::out_word_t   out_word_o
);

  localparam int LW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int NW = $clog2(LIST_DEPTH + 9);
  localparam int KW = $clog2(gap_pkg::MAX_RESULTS);
  localparam int AW = $clog2(gap_pkg::CELLS);

  typedef struct packed {
    logic [2:0]    x;
    logic [2:0]    y;
    logic [NW-1:0] g;
    logic [NW-1:0] f;
  } node_t;

  // Chebyshev distance between two cells
  function automatic logic [2:0] cheb(input logic [2:0] ax, input logic [2:0] ay,
                                      input logic [2:0] bx, input logic [2:0] by);
    logic [2:0] dx;
    logic [2:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return (dx > dy) ? dx : dy;
  endfunction

  function automatic logic in_grid(input logic [2:0] x, input logic [2:0] y);
    return ({1'b0, x} < 4'(gap_pkg::GRID_W)) && ({1'b0, y} < 4'(gap_pkg::GRID_H));
  endfunction

  // Logical open-list index to ring address
  function automatic logic [LW-1:0] wrap_addr(input logic [LW-1:0] base,
                                              input logic [CW-1:0] idx);
    logic [LW:0] s;
    s = (LW+1)'(base) + (LW+1)'(idx);
    if (s >= (LW+1)'(LIST_DEPTH)) s = s - (LW+1)'(LIST_DEPTH);
    return s[LW-1:0];
  endfunction

  // Neighbor offset plus one, per direction code
  function automatic logic [1:0] off_x(input logic [3:0] d);
    unique case (d)
      4'd0, 4'd3, 4'd6: return 2'd0;
      4'd1, 4'd4, 4'd7: return 2'd1;
      4'd2, 4'd5, 4'd8: return 2'd2;
      default:          return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] off_y(input logic [3:0] d);
    unique case (d)
      4'd0, 4'd1, 4'd2: return 2'd0;
      4'd3, 4'd4, 4'd5: return 2'd1;
      4'd6, 4'd7, 4'd8: return 2'd2;
      default:          return 2'd0;
    endcase
  endfunction

  localparam logic [3:0] D_CENTER = 4'd4;
  localparam logic [3:0] D_END    = 4'd9;

  gap_pkg::op_e op;
  assign op = cmd_i.op;

  // Storage
  node_t           open_mem   [LIST_DEPTH];
  node_t           closed_mem [LIST_DEPTH];
  logic            wall_mem   [gap_pkg::CELLS];
  logic [gap_pkg::CELLS-1:0] wall_vld_q;

  node_t           open_rd_q, closed_rd_q;
  logic            wall_dat_q, wall_vq;

  // Search registers
  logic [2:0]      start_x_q, start_y_q, goal_x_q, goal_y_q;
  logic            bad_q;
  node_t           cur_q, nb_q;
  logic [3:0]      d_q;
  logic [CW-1:0]   i_q, j_q, pos_q;
  logic            found_q;
  logic [CW-1:0]   open_cnt_q, closed_cnt_q;
  logic [LW-1:0]   head_q;
  logic [KW-1:0]   k_q;
  logic            out_valid_q;
  gap_pkg::out_word_t out_q;

  // Neighbor of the current node for direction d
  logic [4:0] nx, ny;
  logic       nb_in;
  assign nx    = 5'(cur_q.x) + 5'(off_x(d_q)) - 5'd1;
  assign ny    = 5'(cur_q.y) + 5'(off_y(d_q)) - 5'd1;
  assign nb_in = (nx < 5'(gap_pkg::GRID_W)) && (ny < 5'(gap_pkg::GRID_H));

  logic          wall_rd;
  assign wall_rd = wall_dat_q & wall_vq;

  // Wall map port
  logic [AW-1:0] wall_ra, wall_wa;
  logic          wall_re, wall_we;
  always_comb begin
    wall_re = 1'b1;
    wall_ra = '0;
    unique case (op)
      gap_pkg::OP_START:  wall_ra = {in_word_i.cell_y, in_word_i.cell_x};
      gap_pkg::OP_RDGOAL: wall_ra = {goal_y_q, goal_x_q};
      gap_pkg::OP_NB_RD:  wall_ra = {ny[2:0], nx[2:0]};
      default:            wall_re = 1'b0;
    endcase
  end
  assign wall_wa = {in_word_i.cell_y, in_word_i.cell_x};
  assign wall_we = (op == gap_pkg::OP_LOAD) && in_grid(in_word_i.cell_x, in_word_i.cell_y);

  always_ff @(posedge clk_i) begin
    if (wall_we) wall_mem[wall_wa] <= in_word_i.is_wall;
    if (wall_re) begin
      wall_dat_q <= wall_mem[wall_ra];
      wall_vq    <= wall_vld_q[wall_ra];
    end
  end

  // Open list ring
  logic [LW-1:0] open_ra, open_wa;
  logic          open_re, open_we;
  node_t         open_wd;
  always_comb begin
    open_re = 1'b1;
    open_ra = head_q;
    unique case (op)
      gap_pkg::OP_OS_RD:  open_ra = wrap_addr(head_q, i_q);
      gap_pkg::OP_SH_RD:  open_ra = wrap_addr(head_q, CW'(j_q - CW'(1)));
      gap_pkg::OP_POP_RD: open_ra = head_q;
      default:            open_re = 1'b0;
    endcase
    open_we = 1'b1;
    open_wa = wrap_addr(head_q, j_q);
    open_wd = open_rd_q;
    unique case (op)
      gap_pkg::OP_SH_WR: begin
        open_wa = wrap_addr(head_q, j_q);
        open_wd = open_rd_q;
      end
      gap_pkg::OP_INSERT: begin
        open_wa = wrap_addr(head_q, pos_q);
        open_wd = nb_q;
      end
      default: open_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (open_we) open_mem[open_wa] <= open_wd;
    if (open_re) open_rd_q <= open_mem[open_ra];
  end

  // Closed list
  always_ff @(posedge clk_i) begin
    if (op == gap_pkg::OP_CLOSE) closed_mem[closed_cnt_q[LW-1:0]] <= cur_q;
    if (op == gap_pkg::OP_CS_RD) closed_rd_q <= closed_mem[i_q[LW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_vld_q   <= '0;
      open_cnt_q   <= '0;
      closed_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (wall_we) wall_vld_q[wall_wa] <= 1'b1;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (op)
        gap_pkg::OP_INIT: begin
          open_cnt_q   <= '0;
          closed_cnt_q <= '0;
        end
        gap_pkg::OP_INSERT: open_cnt_q   <= CW'(open_cnt_q + CW'(1));
        gap_pkg::OP_POP:    open_cnt_q   <= CW'(open_cnt_q - CW'(1));
        gap_pkg::OP_CLOSE:  closed_cnt_q <= CW'(closed_cnt_q + CW'(1));
        gap_pkg::OP_OUT_NOPATH, gap_pkg::OP_OUT_FULL,
        gap_pkg::OP_OUT_LAST, gap_pkg::OP_OUT_NEXT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Search payload registers
  always_ff @(posedge clk_i) begin
    unique case (op)
      gap_pkg::OP_START: begin
        start_x_q <= in_word_i.cell_x;
        start_y_q <= in_word_i.cell_y;
        goal_x_q  <= in_word_i.goal_x;
        goal_y_q  <= in_word_i.goal_y;
      end
      gap_pkg::OP_RDGOAL: begin
        bad_q <= wall_rd || !in_grid(start_x_q, start_y_q) || !in_grid(goal_x_q, goal_y_q);
      end
      gap_pkg::OP_INIT: begin
        cur_q.x <= start_x_q;
        cur_q.y <= start_y_q;
        cur_q.g <= '0;
        cur_q.f <= NW'(cheb(start_x_q, start_y_q, goal_x_q, goal_y_q));
        head_q  <= '0;
        k_q     <= '0;
      end
      gap_pkg::OP_D_INIT: d_q <= '0;
      gap_pkg::OP_NEXT_D: d_q <= d_q + 4'd1;
      gap_pkg::OP_NB_RD: begin
        nb_q.x <= nx[2:0];
        nb_q.y <= ny[2:0];
        nb_q.g <= NW'(cur_q.g + NW'(1));
        nb_q.f <= NW'(cur_q.g + NW'(1) + NW'(cheb(nx[2:0], ny[2:0], goal_x_q, goal_y_q)));
      end
      gap_pkg::OP_OS_INIT: begin
        i_q     <= '0;
        pos_q   <= open_cnt_q;
        found_q <= 1'b0;
      end
      gap_pkg::OP_OS_CK: begin
        if (!found_q && (nb_q.f <= open_rd_q.f)) begin
          pos_q   <= i_q;
          found_q <= 1'b1;
        end
        i_q <= CW'(i_q + CW'(1));
      end
      gap_pkg::OP_SH_INIT: j_q <= open_cnt_q;
      gap_pkg::OP_SH_WR:   j_q <= CW'(j_q - CW'(1));
      gap_pkg::OP_POP: begin
        cur_q  <= open_rd_q;
        head_q <= (head_q == LW'(LIST_DEPTH - 1)) ? '0 : LW'(head_q + LW'(1));
        i_q    <= '0;
      end
      gap_pkg::OP_SCAN_INIT: i_q <= '0;
      gap_pkg::OP_STEP_I:    i_q <= CW'(i_q + CW'(1));
      gap_pkg::OP_OUT_NOPATH: out_q <= '{3'd0, 3'd0, gap_pkg::ST_NOPATH, 1'b1};
      gap_pkg::OP_OUT_FULL:   out_q <= '{3'd0, 3'd0, gap_pkg::ST_FULL, 1'b1};
      gap_pkg::OP_OUT_LAST:   out_q <= '{cur_q.x, cur_q.y, gap_pkg::ST_CELL, 1'b1};
      gap_pkg::OP_OUT_NEXT: begin
        out_q <= '{cur_q.x, cur_q.y, gap_pkg::ST_CELL, 1'b0};
        cur_q <= closed_rd_q;
        k_q   <= KW'(k_q + KW'(1));
      end
      default: ;
    endcase
  end

  // Adjacency for the retrace
  logic [2:0] adx, ady;
  assign adx = (closed_rd_q.x > cur_q.x) ? closed_rd_q.x - cur_q.x : cur_q.x - closed_rd_q.x;
  assign ady = (closed_rd_q.y > cur_q.y) ? closed_rd_q.y - cur_q.y : cur_q.y - closed_rd_q.y;

  // Status back to the controller
  always_comb begin
    sts_o.bad         = bad_q || wall_rd;
    sts_o.at_goal     = (cur_q.x == goal_x_q) && (cur_q.y == goal_y_q);
    sts_o.d_end       = (d_q == D_END);
    sts_o.d_center    = (d_q == D_CENTER);
    sts_o.nb_in       = nb_in;
    sts_o.wall        = wall_rd;
    sts_o.os_end      = (i_q == open_cnt_q);
    sts_o.os_hit      = (open_rd_q.x == nb_q.x) && (open_rd_q.y == nb_q.y) &&
                        (open_rd_q.f <= nb_q.f);
    sts_o.open_full   = (open_cnt_q == CW'(LIST_DEPTH));
    sts_o.open_empty  = (open_cnt_q == '0);
    sts_o.sh_end      = (j_q == pos_q);
    sts_o.closed_full = (closed_cnt_q == CW'(LIST_DEPTH));
    sts_o.cs_end      = (i_q == closed_cnt_q);
    sts_o.cs_hit      = (closed_rd_q.x == cur_q.x) && (closed_rd_q.y == cur_q.y) &&
                        (closed_rd_q.f <= cur_q.f);
    sts_o.rt_hit      = (adx <= 3'd1) && (ady <= 3'd1) &&
                        ((NW+1)'(closed_rd_q.g) + (NW+1)'(1) == (NW+1)'(cur_q.g));
    sts_o.rt_stop     = ((cur_q.x == start_x_q) && (cur_q.y == start_y_q)) ||
                        (k_q == KW'(gap_pkg::MAX_RESULTS - 1));
    sts_o.out_taken   = out_valid_q && !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

### design/grid_astar_path_search.sv
// Channel | Direction | Handshake              | Word
// in      | input     | in_valid_i / in_stall_o   | gap_pkg::in_word_t
// out     | output    | out_valid_o / out_stall_i | gap_pkg::out_word_t
//
// A load word is written to the wall map without leaving idle. A search holds
// off new input until its last result word has been taken; its length is set
// by the list scans: a scan of the open list for each neighbor tried, a move
// per shifted entry on insert, and a closed-list scan on each pop and retrace step.
// Reset clears the wall map and both list counts; no clearing pass is needed.
// A stalled result holds the controller until it is taken.
module grid_astar_path_search #(
  parameter int LIST_DEPTH = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gap_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gap_pkg::out_word_t out_word_o
);

  gap_pkg::cmd_t cmd;
  gap_pkg::sts_t sts;

  gap_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (in_word_i.opcode),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  gap_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

### design/gap_chk.sv
`include "grid_astar_path_search_macros.svh"

module gap_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input gap_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input gap_pkg::out_word_t out_word_o
);

  // A pending result word stays offered
  `GAP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result word dropped")

  // A stalled result word does not change
  `GAP_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(out_word_o), "result word changed")

  // Error results end the search and carry no cell
  `GAP_ASSERT(a_err_last, out_valid_o && out_word_o.status != gap_pkg::ST_CELL |-> out_word_o.last && out_word_o.path_x == 3'd0 && out_word_o.path_y == 3'd0, "bad error word")

  // No input word is taken while a search has a result pending
  `GAP_ASSERT_ALWAYS(a_busy_stall, out_valid_o |-> in_stall_o, "input taken during search")

endmodule

bind grid_astar_path_search gap_chk u_gap_chk (.*);
